[rtl/core/frlm_pkg.sv]
// frlm_pkg: shared types, constants and helpers for the loop timing monitor
// used by frlm_div and fixed_rate_loop_timing_monitor; no dependencies
package frlm_pkg;

    localparam int TIME_BITS = 64;
    localparam int DIV_W     = 64;
    localparam int PER_W     = 20;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    localparam logic [2:0] MODE_RESTART = 3'd0;
    localparam logic [2:0] MODE_BEGIN   = 3'd1;
    localparam logic [2:0] MODE_DELAY   = 3'd2;
    localparam logic [2:0] MODE_END     = 3'd3;
    localparam logic [2:0] MODE_UPTIME  = 3'd4;

    localparam logic [DIV_W-1:0] US_PER_S  = 64'd1000000;

    // uptime in ms: (x >> 3) / 125 as a multiply by ceil(2^46 / 125), exact below 2^39
    localparam logic [39:0] RECIP_125  = 40'd562949953422;
    // 1000 * 2^32 us: from here on the uptime saturates
    localparam logic [63:0] UPT_SAT_US = 64'd4294967296000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_wait_us;
        logic [31:0] elapsed_ms;
        logic [31:0] loop_total;
        logic [31:0] last_interval_us;
        logic [31:0] last_work_us;
        logic [31:0] max_work_us;
        logic [31:0] last_lateness_us;
        logic [31:0] late_total;
        logic        last_was_late;
        logic        schedule_saturated;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] add_sat(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

endpackage

[rtl/core/frlm_div.sv]
// frlm_div: restoring divider, one quotient bit per cycle
// depends on frlm_pkg
module frlm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [frlm_pkg::DIV_W-1:0]     dividend,
    input  logic [frlm_pkg::PER_W-1:0]     divisor,
    output frlm_pkg::div_stat_t            stat,
    output logic [frlm_pkg::DIV_W-1:0]     quotient,
    output logic [frlm_pkg::PER_W-1:0]     remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [frlm_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [frlm_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [frlm_pkg::PER_W-1:0]    rem_reg, rem_next;
    logic [frlm_pkg::PER_W-1:0]    dvs_reg, dvs_next;
    logic [frlm_pkg::PER_W:0]      trial;
    logic                          ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[frlm_pkg::DIV_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = frlm_pkg::CNT_W'(frlm_pkg::DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? frlm_pkg::PER_W'(trial - {1'b0, dvs_reg})
                          : trial[frlm_pkg::PER_W-1:0];
            quo_next = {quo_reg[frlm_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == frlm_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/fixed_rate_loop_timing_monitor.sv]
// fixed_rate_loop_timing_monitor: supervises a fixed-rate loop, one result per request
// sequence after the accepting edge: EXEC, USTART, UMLO and UMHI, then the result is valid in OUT;
// a restart with nonzero rate or a late delay request also waits in DIVW on the shared divider
// one request at a time: no new request is taken until the result has left OUT, plus stalls
// reset: rst_n asynchronous active low, clears all statistics, period 1 us, rate 0
// depends on frlm_pkg and frlm_div
module fixed_rate_loop_timing_monitor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  frlm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output frlm_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data
);

    localparam int TB = frlm_pkg::TIME_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_DIVW   = 3'd2;
    localparam logic [2:0] ST_USTART = 3'd3;
    localparam logic [2:0] ST_UMLO   = 3'd4;
    localparam logic [2:0] ST_UMHI   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [2:0]                    mode_reg, mode_next;
    logic [TB-1:0]                 now_reg, now_next;
    logic [15:0]                   rate_reg, rate_next;
    logic [TB-1:0]                 boot_reg, boot_next;
    logic [TB-1:0]                 prev_reg, prev_next;
    logic [TB-1:0]                 nd_reg, nd_next;
    logic [TB-1:0]                 exp_reg, exp_next;
    logic [frlm_pkg::PER_W-1:0]    period_reg, period_next;
    logic [31:0]                   begin_cnt_reg, begin_cnt_next;
    logic [31:0]                   interval_reg, interval_next;
    logic [31:0]                   work_reg, work_next;
    logic [31:0]                   peak_reg, peak_next;
    logic [31:0]                   recl_reg, recl_next;
    logic [31:0]                   runl_reg, runl_next;
    logic [31:0]                   late_cnt_reg, late_cnt_next;
    logic                          late_flag_reg, late_flag_next;
    logic                          exp_valid_reg, exp_valid_next;
    logic                          running_reg, running_next;
    logic [31:0]                   delay_reg, delay_next;
    logic [31:0]                   uptime_reg, uptime_next;

    // uptime: saturation flag, time over 8, low partial product
    logic                          upt_sat_reg, upt_sat_next;
    logic [38:0]                   upt_y_reg, upt_y_next;
    logic [59:0]                   upt_lo_reg, upt_lo_next;
    logic [63:0]                   upt_diff;
    logic [58:0]                   upt_hi_prod;
    logic [78:0]                   upt_sum;

    // shared divider
    logic                          div_start;
    logic [frlm_pkg::DIV_W-1:0]    div_dividend;
    logic [frlm_pkg::PER_W-1:0]    div_divisor;
    frlm_pkg::div_stat_t           div_stat;
    logic [frlm_pkg::DIV_W-1:0]    div_quo;
    logic [frlm_pkg::PER_W-1:0]    div_rem;

    // delay request tail: commit a deadline and report the wait
    logic                          tail_go;
    logic [TB-1:0]                 tail_nd;
    logic [31:0]                   tail_runl;
    logic [TB-1:0]                 over;
    logic [31:0]                   lat;
    logic [31:0]                   runl_max;
    logic [TB:0]                   skip_sum;

    frlm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // lateness and skipped-deadline arithmetic for a late delay request
    // over = q*period + rem, so deadline + (q+1)*period = now - rem + period
    assign over     = now_reg - nd_reg;
    assign lat      = frlm_pkg::sat32(64'(over));
    assign runl_max = (lat > runl_reg) ? lat : runl_reg;
    assign skip_sum = {1'b0, now_reg} - (TB+1)'(div_rem) + (TB+1)'(period_reg);

    // uptime in ms by reciprocal multiply, split into a 20-bit low part and a 19-bit high part of the operand
    assign upt_diff    = (now_reg >= boot_reg) ? 64'(now_reg - boot_reg) : 64'd0;
    assign upt_hi_prod = upt_y_reg[38:20] * frlm_pkg::RECIP_125;
    assign upt_sum     = {upt_hi_prod, 20'd0} + 79'(upt_lo_reg);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        rate_next      = cfg_we ? cfg_data : rate_reg;
        boot_next      = boot_reg;
        prev_next      = prev_reg;
        nd_next        = nd_reg;
        exp_next       = exp_reg;
        period_next    = period_reg;
        begin_cnt_next = begin_cnt_reg;
        interval_next  = interval_reg;
        work_next      = work_reg;
        peak_next      = peak_reg;
        recl_next      = recl_reg;
        runl_next      = runl_reg;
        late_cnt_next  = late_cnt_reg;
        late_flag_next = late_flag_reg;
        exp_valid_next = exp_valid_reg;
        running_next   = running_reg;
        delay_next     = delay_reg;
        uptime_next    = uptime_reg;
        upt_sat_next   = upt_sat_reg;
        upt_y_next     = upt_y_reg;
        upt_lo_next    = upt_lo_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        tail_go        = 1'b0;
        tail_nd        = nd_reg;
        tail_runl      = runl_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_data.mode;
                    now_next   = in_data.now_us[TB-1:0];
                    delay_next = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_USTART;
                unique case (mode_reg)
                    frlm_pkg::MODE_RESTART:
                    begin
                        boot_next      = now_reg;
                        prev_next      = '0;
                        nd_next        = now_reg;
                        exp_next       = '0;
                        begin_cnt_next = '0;
                        interval_next  = '0;
                        work_next      = '0;
                        peak_next      = '0;
                        recl_next      = '0;
                        runl_next      = '0;
                        late_cnt_next  = '0;
                        late_flag_next = 1'b0;
                        exp_valid_next = 1'b0;
                        running_next   = 1'b0;
                        if (rate_reg == '0)
                        begin
                            period_next = frlm_pkg::PER_W'(1);
                        end
                        else
                        begin
                            // round(1e6 / rate)
                            div_start    = 1'b1;
                            div_dividend = frlm_pkg::US_PER_S
                                         + frlm_pkg::DIV_W'(rate_reg[15:1]);
                            div_divisor  = frlm_pkg::PER_W'(rate_reg);
                            state_next   = ST_DIVW;
                        end
                    end
                    frlm_pkg::MODE_BEGIN:
                    begin
                        runl_next = '0;
                        if (running_reg)
                        begin
                            interval_next = (now_reg >= prev_reg)
                                          ? frlm_pkg::sat32(64'(now_reg - prev_reg)) : '0;
                            if (exp_valid_reg && now_reg > exp_reg)
                            begin
                                runl_next = frlm_pkg::sat32(64'(now_reg - exp_reg));
                            end
                        end
                        else
                        begin
                            interval_next = '0;
                            nd_next       = frlm_pkg::add_sat(now_reg, TB'(period_reg));
                            running_next  = 1'b1;
                        end
                        prev_next = now_reg;
                        if (begin_cnt_reg != 32'hFFFF_FFFF)
                        begin
                            begin_cnt_next = begin_cnt_reg + 32'd1;
                        end
                    end
                    frlm_pkg::MODE_DELAY:
                    begin
                        if (running_reg && nd_reg != frlm_pkg::TMAX)
                        begin
                            if (now_reg > nd_reg)
                            begin
                                // count the missed periods on the divider
                                div_start    = 1'b1;
                                div_dividend = frlm_pkg::DIV_W'(over);
                                div_divisor  = period_reg;
                                state_next   = ST_DIVW;
                            end
                            else
                            begin
                                tail_go = 1'b1;
                            end
                        end
                    end
                    frlm_pkg::MODE_END:
                    begin
                        if (running_reg)
                        begin
                            work_next = (now_reg >= prev_reg)
                                      ? frlm_pkg::sat32(64'(now_reg - prev_reg)) : '0;
                            if (work_next > peak_reg)
                            begin
                                peak_next = work_next;
                            end
                        end
                    end
                    default:
                    begin
                        // uptime query and unknown modes change nothing
                    end
                endcase
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_USTART;
                    if (mode_reg == frlm_pkg::MODE_RESTART)
                    begin
                        period_next = div_quo[frlm_pkg::PER_W-1:0];
                    end
                    else if (skip_sum[TB])
                    begin
                        // schedule overflow: pin the deadline, lateness not recorded
                        runl_next = runl_max;
                        nd_next   = frlm_pkg::TMAX;
                    end
                    else
                    begin
                        tail_go   = 1'b1;
                        tail_nd   = skip_sum[TB-1:0];
                        tail_runl = runl_max;
                    end
                end
            end
            ST_USTART:
            begin
                upt_sat_next = upt_diff >= frlm_pkg::UPT_SAT_US;
                upt_y_next   = upt_diff[41:3];
                state_next   = ST_UMLO;
            end
            ST_UMLO:
            begin
                upt_lo_next = upt_y_reg[19:0] * frlm_pkg::RECIP_125;
                state_next  = ST_UMHI;
            end
            ST_UMHI:
            begin
                uptime_next = upt_sat_reg ? 32'hFFFF_FFFF : upt_sum[77:46];
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (tail_go)
        begin
            recl_next      = tail_runl;
            runl_next      = tail_runl;
            late_flag_next = tail_runl != '0;
            if (tail_runl != '0 && late_cnt_reg != 32'hFFFF_FFFF)
            begin
                late_cnt_next = late_cnt_reg + 32'd1;
            end
            exp_next       = tail_nd;
            exp_valid_next = 1'b1;
            delay_next     = frlm_pkg::sat32(64'(tail_nd - now_reg));
            nd_next        = frlm_pkg::add_sat(tail_nd, TB'(period_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= '0;
            boot_reg      <= '0;
            prev_reg      <= '0;
            nd_reg        <= '0;
            exp_reg       <= '0;
            period_reg    <= frlm_pkg::PER_W'(1);
            begin_cnt_reg <= '0;
            interval_reg  <= '0;
            work_reg      <= '0;
            peak_reg      <= '0;
            recl_reg      <= '0;
            runl_reg      <= '0;
            late_cnt_reg  <= '0;
            late_flag_reg <= 1'b0;
            exp_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            boot_reg      <= boot_next;
            prev_reg      <= prev_next;
            nd_reg        <= nd_next;
            exp_reg       <= exp_next;
            period_reg    <= period_next;
            begin_cnt_reg <= begin_cnt_next;
            interval_reg  <= interval_next;
            work_reg      <= work_next;
            peak_reg      <= peak_next;
            recl_reg      <= recl_next;
            runl_reg      <= runl_next;
            late_cnt_reg  <= late_cnt_next;
            late_flag_reg <= late_flag_next;
            exp_valid_reg <= exp_valid_next;
            running_reg   <= running_next;
        end
    end

    // request payload, result words and uptime datapath
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        now_reg     <= now_next;
        delay_reg   <= delay_next;
        uptime_reg  <= uptime_next;
        upt_sat_reg <= upt_sat_next;
        upt_y_reg   <= upt_y_next;
        upt_lo_reg  <= upt_lo_next;
    end

    // handshake and result
    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = state_reg == ST_OUT;

    assign out_data.next_wait_us       = delay_reg;
    assign out_data.elapsed_ms         = uptime_reg;
    assign out_data.loop_total         = begin_cnt_reg;
    assign out_data.last_interval_us   = interval_reg;
    assign out_data.last_work_us       = work_reg;
    assign out_data.max_work_us        = peak_reg;
    assign out_data.last_lateness_us   = recl_reg;
    assign out_data.late_total         = late_cnt_reg;
    assign out_data.last_was_late      = late_flag_reg;
    assign out_data.schedule_saturated = nd_reg == frlm_pkg::TMAX;

`ifndef SYNTHESIS
    // divider is never restarted while a divide is in flight
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // no new request is taken while a result is pending
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // execution follows only an accepted request
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $past(in_valid && !in_stall))
        else $error("exec state without accepted request");

    // late count only steps by one or clears on restart
    a_late_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (late_cnt_reg != $past(late_cnt_reg)) |->
            (late_cnt_reg == $past(late_cnt_reg) + 32'd1 || late_cnt_reg == '0))
        else $error("late count jumped");

    // the result is stable once presented
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("result changed while stalled");
`endif

endmodule
